### hdl/slot_header_allocator_macros.svh
// ---------------------------------------------------------------------------
// Slot header allocator assertion macros
// Shared assertion forms for the slot header allocator RTL.
// ---------------------------------------------------------------------------
`ifndef SLOT_HEADER_ALLOCATOR_MACROS_SVH
`define SLOT_HEADER_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define SHA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sha: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define SHA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sha: next-cycle check failed");

`endif

### hdl/sha_pkg.sv
// ---------------------------------------------------------------------------
// Slot header allocator package
// Widths, operation and status codes, controller states and the
// command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package sha_pkg;

   localparam int MAX_SLOTS_DEF   = 1024;
   localparam int JUMP_LENGTH_DEF = 8;

   localparam int CSR_W     = 11;
   localparam int FUNC_W    = 3;
   localparam int IDX_W     = 10;
   localparam int STATUS_W  = 3;
   localparam int HDR_W     = 8;
   localparam int HDR_CNT_W = 7;

   localparam logic [CSR_W-1:0] SLOT_COUNT_RST = 11'd1024;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_FREE    = 3'd0,
      FUNC_MARK    = 3'd1,
      FUNC_CNT_UP  = 3'd2,
      FUNC_CNT_DN  = 3'd3,
      FUNC_RST_GRP = 3'd4,
      FUNC_TEST    = 3'd5,
      FUNC_FIND    = 3'd6,
      FUNC_NONE    = 3'd7
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK      = 3'd0,
      STS_RANGE   = 3'd1,
      STS_FREE    = 3'd2,
      STS_USED    = 3'd3,
      STS_NO_FREE = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_OP_WR,
      ST_HEAD_RD,
      ST_HEAD_CHK,
      ST_SLOT_RD,
      ST_SLOT_CHK,
      ST_HIT,
      ST_MISS
   } state_type;

   typedef struct packed {
      logic idle;
      logic clr_step;
      logic wr_op;
      logic rd_scan;
      logic grp_next;
      logic scan_next;
      logic ld_found;
      logic ld_nofree;
   } ctl_cmd_type;

   typedef struct packed {
      logic req_take;
      logic req_find;
      logic clr_last;
      logic grp_end;
      logic head_zero;
      logic hit;
      logic slot_end;
      logic rsp_busy;
   } dp_stat_type;

endpackage

### hdl/slot_header_allocator.sv
// ---------------------------------------------------------------------------
// Slot header allocator
// One header byte per record slot (used bit and group hint count), with
// per-slot updates and a group-skipping search for the first free slot.
// ---------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  req_      in         req_valid/req_stall   req_func, req_slot_index
//  rsp_      out        rsp_valid/rsp_stall   rsp_status, rsp_slot_used, rsp_found_index
//  csr_      in         csr_wr_en             csr_wr_data (slot count)
//
//  Index operations accept the word with a header read, then write back.
//  Find reads the head of each group visited, and each further slot examined in
//  a group whose head count is non-zero, then loads a hit or a no-free result;
//  every read goes through the single header port.
//  After reset a clearing pass zeroes the store one header at a time; req_stall
//  is high meanwhile. One word is in flight; the next is accepted while a
//  result waits in the output register, and rsp_stall holds the block on finish.
// ---------------------------------------------------------------------------
`include "slot_header_allocator_macros.svh"

module slot_header_allocator #(
   parameter int MAX_SLOTS   = sha_pkg::MAX_SLOTS_DEF,
   parameter int JUMP_LENGTH = sha_pkg::JUMP_LENGTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sha_pkg::FUNC_W-1:0]    req_func,
   input  logic [sha_pkg::IDX_W-1:0]     req_slot_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sha_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_slot_used,
   output logic [sha_pkg::IDX_W-1:0]     rsp_found_index,
   input  logic                          csr_wr_en,
   input  logic [sha_pkg::CSR_W-1:0]     csr_wr_data
);

   sha_pkg::ctl_cmd_type ctl_cmd;
   sha_pkg::dp_stat_type dp_stat;

   sha_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (dp_stat),
      .cmd   (ctl_cmd)
   );

   sha_dp #(
      .MAX_SLOTS   (MAX_SLOTS),
      .JUMP_LENGTH (JUMP_LENGTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (ctl_cmd),
      .stat            (dp_stat),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_slot_index  (req_slot_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_slot_used   (rsp_slot_used),
      .rsp_found_index (rsp_found_index),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   // one word at a time: the cycle after an accept the input is held off
   `SHA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall)

   // a result is only loaded when the output register is free or draining
   `SHA_ASSERT_SAME(a_load_when_free, clock, reset, ctl_cmd.wr_op || ctl_cmd.ld_found || ctl_cmd.ld_nofree, !(rsp_valid && rsp_stall))

   // clearing pass keeps the input stalled and never overlaps a write-back
   `SHA_ASSERT_SAME(a_clear_exclusive, clock, reset, ctl_cmd.clr_step, req_stall && !ctl_cmd.wr_op && !ctl_cmd.rd_scan)

endmodule

### hdl/sha_ctrl.sv
// ---------------------------------------------------------------------------
// Slot header allocator controller
// Sequences the clearing pass, header read-modify-write and the free scan.
// ---------------------------------------------------------------------------
module sha_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  sha_pkg::dp_stat_type stat,
   output sha_pkg::ctl_cmd_type cmd
);

   sha_pkg::state_type state_ff;
   sha_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha_pkg::ST_CLEAR: begin
            if (stat.clr_last) state_in = sha_pkg::ST_IDLE;
         end
         sha_pkg::ST_IDLE: begin
            if (stat.req_take) begin
               state_in = stat.req_find ? sha_pkg::ST_HEAD_RD : sha_pkg::ST_OP_WR;
            end
         end
         sha_pkg::ST_OP_WR: begin
            if (!stat.rsp_busy) state_in = sha_pkg::ST_IDLE;
         end
         sha_pkg::ST_HEAD_RD: begin
            state_in = stat.grp_end ? sha_pkg::ST_MISS : sha_pkg::ST_HEAD_CHK;
         end
         sha_pkg::ST_HEAD_CHK: begin
            if (stat.head_zero || (!stat.hit && stat.slot_end)) begin
               state_in = sha_pkg::ST_HEAD_RD;
            end else if (stat.hit) begin
               state_in = sha_pkg::ST_HIT;
            end else begin
               state_in = sha_pkg::ST_SLOT_RD;
            end
         end
         sha_pkg::ST_SLOT_RD: begin
            state_in = sha_pkg::ST_SLOT_CHK;
         end
         sha_pkg::ST_SLOT_CHK: begin
            if (stat.hit) begin
               state_in = sha_pkg::ST_HIT;
            end else if (stat.slot_end) begin
               state_in = sha_pkg::ST_HEAD_RD;
            end else begin
               state_in = sha_pkg::ST_SLOT_RD;
            end
         end
         sha_pkg::ST_HIT,
         sha_pkg::ST_MISS: begin
            if (!stat.rsp_busy) state_in = sha_pkg::ST_IDLE;
         end
         default: state_in = sha_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         sha_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
         sha_pkg::ST_IDLE:  cmd.idle     = 1'b1;
         sha_pkg::ST_OP_WR: cmd.wr_op    = !stat.rsp_busy;
         sha_pkg::ST_HEAD_RD: begin
            cmd.rd_scan = !stat.grp_end;
         end
         sha_pkg::ST_HEAD_CHK: begin
            if (stat.head_zero || (!stat.hit && stat.slot_end)) begin
               cmd.grp_next = 1'b1;
            end else if (!stat.hit) begin
               cmd.scan_next = 1'b1;
            end
         end
         sha_pkg::ST_SLOT_RD: cmd.rd_scan = 1'b1;
         sha_pkg::ST_SLOT_CHK: begin
            if (!stat.hit) begin
               if (stat.slot_end) cmd.grp_next  = 1'b1;
               else               cmd.scan_next = 1'b1;
            end
         end
         sha_pkg::ST_HIT:  cmd.ld_found  = !stat.rsp_busy;
         sha_pkg::ST_MISS: cmd.ld_nofree = !stat.rsp_busy;
         default: cmd = '0;
      endcase
   end

endmodule

### hdl/sha_dp.sv
// ---------------------------------------------------------------------------
// Slot header allocator datapath
// Header store, slot count register, scan cursors and the result register.
// ---------------------------------------------------------------------------
module sha_dp #(
   parameter int MAX_SLOTS   = sha_pkg::MAX_SLOTS_DEF,
   parameter int JUMP_LENGTH = sha_pkg::JUMP_LENGTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sha_pkg::ctl_cmd_type          cmd,
   output sha_pkg::dp_stat_type          stat,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sha_pkg::FUNC_W-1:0]    req_func,
   input  logic [sha_pkg::IDX_W-1:0]     req_slot_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sha_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_slot_used,
   output logic [sha_pkg::IDX_W-1:0]     rsp_found_index,
   input  logic                          csr_wr_en,
   input  logic [sha_pkg::CSR_W-1:0]     csr_wr_data
);

   localparam int AW = $clog2(MAX_SLOTS);
   localparam int CW = $clog2(MAX_SLOTS + JUMP_LENGTH + 1);
   localparam int WW = (CW > sha_pkg::CSR_W) ? CW : sha_pkg::CSR_W;

   logic [sha_pkg::HDR_W-1:0] mem [MAX_SLOTS];

   logic [sha_pkg::HDR_W-1:0]  rd_data_ff;
   logic [sha_pkg::CSR_W-1:0]  slot_count_ff;
   logic [AW-1:0]              clr_ff;
   sha_pkg::func_type          op_func_ff;
   logic [sha_pkg::IDX_W-1:0]  op_idx_ff;
   logic [CW-1:0]              grp_ff;
   logic [CW-1:0]              scan_ff;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   sha_pkg::status_type        rsp_status_ff;
   logic                       rsp_used_ff;
   logic [sha_pkg::IDX_W-1:0]  rsp_found_ff;

   logic [WW-1:0]              eff_n;
   logic [WW-1:0]              slot_cnt_w;
   logic [WW-1:0]              req_idx_w;
   logic [WW-1:0]              op_idx_w;
   logic [WW-1:0]              scan_w;
   logic [WW-1:0]              scan_nx_w;
   logic [WW-1:0]              grp_lim_w;
   logic                       op_in_range;
   logic                       mem_we;
   logic                       mem_re;
   logic [AW-1:0]              mem_wa;
   logic [AW-1:0]              mem_ra;
   logic [sha_pkg::HDR_W-1:0]  mem_wd;
   logic [sha_pkg::HDR_W-1:0]  hdr_new;
   sha_pkg::status_type        op_status;
   logic                       op_used;
   logic                       rsp_load;

   // effective slot count, saturated at the store depth
   assign slot_cnt_w  = WW'(slot_count_ff);
   assign eff_n       = (slot_cnt_w > WW'(MAX_SLOTS)) ? WW'(MAX_SLOTS) : slot_cnt_w;
   assign req_idx_w   = WW'(req_slot_index);
   assign op_idx_w    = WW'(op_idx_ff);
   assign scan_w      = WW'(scan_ff);
   assign scan_nx_w   = scan_w + WW'(1);
   assign grp_lim_w   = WW'(grp_ff) + WW'(JUMP_LENGTH);
   assign op_in_range = op_idx_w < eff_n;

   assign req_stall      = ~cmd.idle;
   assign stat.req_take  = cmd.idle & req_valid;
   assign stat.req_find  = (sha_pkg::func_type'(req_func) == sha_pkg::FUNC_FIND);
   assign stat.clr_last  = (clr_ff == AW'(MAX_SLOTS - 1));
   assign stat.grp_end   = (WW'(grp_ff) >= eff_n);
   assign stat.head_zero = (rd_data_ff[sha_pkg::HDR_W-1:1] == '0);
   assign stat.hit       = ~rd_data_ff[0];
   assign stat.slot_end  = (scan_nx_w >= eff_n) || (scan_nx_w >= grp_lim_w);
   assign stat.rsp_busy  = rsp_valid_ff & rsp_stall;

   // header store: one write and one registered read per cycle
   assign mem_we = cmd.clr_step | (cmd.wr_op & op_in_range);
   assign mem_wa = cmd.clr_step ? clr_ff : op_idx_w[AW-1:0];
   assign mem_wd = cmd.clr_step ? '0 : hdr_new;
   assign mem_re = stat.req_take | cmd.rd_scan;
   assign mem_ra = cmd.rd_scan ? scan_ff[AW-1:0] : req_idx_w[AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (mem_re) rd_data_ff <= mem[mem_ra];
   end

   // header update for index operations
   always_comb begin
      hdr_new   = rd_data_ff;
      op_status = sha_pkg::STS_OK;
      op_used   = 1'b0;
      if (!op_in_range) begin
         op_status = sha_pkg::STS_RANGE;
      end else begin
         unique case (op_func_ff)
            sha_pkg::FUNC_FREE: begin
               if (!rd_data_ff[0]) op_status = sha_pkg::STS_FREE;
               else                hdr_new[0] = 1'b0;
            end
            sha_pkg::FUNC_MARK: begin
               if (rd_data_ff[0]) op_status = sha_pkg::STS_USED;
               else               hdr_new[0] = 1'b1;
            end
            sha_pkg::FUNC_CNT_UP: begin
               if (rd_data_ff[sha_pkg::HDR_W-1:1] < sha_pkg::HDR_CNT_W'(JUMP_LENGTH)) begin
                  hdr_new = rd_data_ff + sha_pkg::HDR_W'(2);
               end
            end
            sha_pkg::FUNC_CNT_DN: begin
               if (rd_data_ff[sha_pkg::HDR_W-1:1] != '0) begin
                  hdr_new = rd_data_ff - sha_pkg::HDR_W'(2);
               end
            end
            sha_pkg::FUNC_RST_GRP: hdr_new = {sha_pkg::HDR_CNT_W'(JUMP_LENGTH), 1'b0};
            sha_pkg::FUNC_TEST:    op_used = rd_data_ff[0];
            sha_pkg::FUNC_FIND,
            sha_pkg::FUNC_NONE:    hdr_new = rd_data_ff;
            default:               hdr_new = rd_data_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= sha_pkg::SLOT_COUNT_RST;
         clr_ff        <= '0;
      end else begin
         if (csr_wr_en)    slot_count_ff <= csr_wr_data;
         if (cmd.clr_step) clr_ff        <= clr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (stat.req_take) begin
         op_func_ff <= sha_pkg::func_type'(req_func);
         op_idx_ff  <= req_slot_index;
      end
   end

   // scan cursors: group start and slot under test
   always_ff @(posedge clock) begin
      if (reset) begin
         grp_ff  <= '0;
         scan_ff <= '0;
      end else if (stat.req_take) begin
         grp_ff  <= '0;
         scan_ff <= '0;
      end else if (cmd.grp_next) begin
         grp_ff  <= grp_ff + CW'(JUMP_LENGTH);
         scan_ff <= grp_ff + CW'(JUMP_LENGTH);
      end else if (cmd.scan_next) begin
         scan_ff <= scan_ff + CW'(1);
      end
   end

   // result word register
   assign rsp_load     = cmd.wr_op | cmd.ld_found | cmd.ld_nofree;
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_op) begin
         rsp_status_ff <= op_status;
         rsp_used_ff   <= op_used;
         rsp_found_ff  <= '0;
      end else if (cmd.ld_found) begin
         rsp_status_ff <= sha_pkg::STS_OK;
         rsp_used_ff   <= 1'b0;
         rsp_found_ff  <= scan_w[sha_pkg::IDX_W-1:0];
      end else if (cmd.ld_nofree) begin
         rsp_status_ff <= sha_pkg::STS_NO_FREE;
         rsp_used_ff   <= 1'b0;
         rsp_found_ff  <= '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_used   = rsp_used_ff;
   assign rsp_found_index = rsp_found_ff;

endmodule

### tb/sv/slot_header_allocator_test.sv
// ---------------------------------------------------------------------------
// Slot header allocator testbench
// A table of directed words is followed by random phases at several slot
// counts and idling patterns. Every accepted request is run through a local
// model of the header store, and each response is compared, field by field,
// with the oldest pending expectation.
// ---------------------------------------------------------------------------
module slot_header_allocator_test;
   import sha_pkg::*;

   localparam int JL             = JUMP_LENGTH_DEF;
   localparam int NSLOT          = MAX_SLOTS_DEF;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int PHASE_WORDS    = 45;

   typedef struct packed {
      status_type       st;
      logic             used;
      logic [IDX_W-1:0] found;
   } rsp_word_type;

   typedef struct packed {
      logic             is_cfg;
      logic [CSR_W-1:0] cfg;
      func_type         f;
      logic [IDX_W-1:0] idx;
      logic             chk;
      rsp_word_type     ex;
   } dir_row_type;

   // expected response typed in only where it is obvious; the rest use the model
   localparam dir_row_type DIR_TAB [0:25] = '{
      '{1'b0, 11'd0,    FUNC_TEST,    10'd0,    1'b1, '{STS_OK,      1'b0, 10'd0}},
      '{1'b0, 11'd0,    FUNC_FIND,    10'd0,    1'b1, '{STS_NO_FREE, 1'b0, 10'd0}},
      '{1'b0, 11'd0,    FUNC_FREE,    10'd1023, 1'b1, '{STS_FREE,    1'b0, 10'd0}},
      '{1'b0, 11'd0,    FUNC_MARK,    10'd1023, 1'b1, '{STS_OK,      1'b0, 10'd0}},
      '{1'b0, 11'd0,    FUNC_MARK,    10'd1023, 1'b1, '{STS_USED,    1'b0, 10'd0}},
      '{1'b0, 11'd0,    FUNC_TEST,    10'd1023, 1'b1, '{STS_OK,      1'b1, 10'd0}},
      '{1'b0, 11'd0,    FUNC_FREE,    10'd1023, 1'b1, '{STS_OK,      1'b0, 10'd0}},
      '{1'b0, 11'd0,    FUNC_RST_GRP, 10'd0,    1'b1, '{STS_OK,      1'b0, 10'd0}},
      '{1'b0, 11'd0,    FUNC_FIND,    10'd0,    1'b1, '{STS_OK,      1'b0, 10'd0}},
      '{1'b0, 11'd0,    FUNC_MARK,    10'd0,    1'b1, '{STS_OK,      1'b0, 10'd0}},
      '{1'b0, 11'd0,    FUNC_FIND,    10'd1023, 1'b0, '{STS_OK,      1'b0, 10'd0}},
      '{1'b0, 11'd0,    FUNC_CNT_UP,  10'd8,    1'b0, '{STS_OK,      1'b0, 10'd0}},
      '{1'b0, 11'd0,    FUNC_CNT_DN,  10'd8,    1'b0, '{STS_OK,      1'b0, 10'd0}},
      '{1'b0, 11'd0,    FUNC_CNT_DN,  10'd8,    1'b0, '{STS_OK,      1'b0, 10'd0}},
      '{1'b0, 11'd0,    FUNC_CNT_UP,  10'd0,    1'b0, '{STS_OK,      1'b0, 10'd0}},
      '{1'b0, 11'd0,    FUNC_NONE,    10'd5,    1'b1, '{STS_OK,      1'b0, 10'd0}},
      '{1'b1, 11'd1,    FUNC_NONE,    10'd0,    1'b0, '{STS_OK,      1'b0, 10'd0}},
      '{1'b0, 11'd0,    FUNC_TEST,    10'd1,    1'b1, '{STS_RANGE,   1'b0, 10'd0}},
      '{1'b0, 11'd0,    FUNC_NONE,    10'd1023, 1'b1, '{STS_RANGE,   1'b0, 10'd0}},
      '{1'b0, 11'd0,    FUNC_MARK,    10'd0,    1'b1, '{STS_USED,    1'b0, 10'd0}},
      '{1'b0, 11'd0,    FUNC_FIND,    10'd0,    1'b1, '{STS_NO_FREE, 1'b0, 10'd0}},
      '{1'b1, 11'd1023, FUNC_NONE,    10'd0,    1'b0, '{STS_OK,      1'b0, 10'd0}},
      '{1'b0, 11'd0,    FUNC_TEST,    10'd1023, 1'b1, '{STS_RANGE,   1'b0, 10'd0}},
      '{1'b0, 11'd0,    FUNC_FIND,    10'd0,    1'b0, '{STS_OK,      1'b0, 10'd0}},
      // slot count above the store depth saturates to the full store
      '{1'b1, 11'd2047, FUNC_NONE,    10'd0,    1'b0, '{STS_OK,      1'b0, 10'd0}},
      '{1'b0, 11'd0,    FUNC_TEST,    10'd1023, 1'b1, '{STS_OK,      1'b0, 10'd0}}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   func_type         req_func = FUNC_NONE;
   logic [IDX_W-1:0] req_slot_index = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic             rsp_slot_used;
   logic [IDX_W-1:0] rsp_found_index;
   logic             csr_wr_en = 1'b0;
   logic [CSR_W-1:0] csr_wr_data = '0;

   // typed expectation travelling with the request word
   logic             req_chk = 1'b0;
   rsp_word_type     req_ref = '0;

   logic [HDR_W-1:0] hdr_model [NSLOT];
   logic [CSR_W-1:0] slot_limit_model;
   rsp_word_type     pending_rsp [$];
   rsp_word_type     next_rsp;
   rsp_word_type     got_rsp;
   bit               mismatch_seen = 1'b0;
   int               idle_cycles = 0;
   int               words_sent = 0;
   int               snd_pct = 0;
   int               rcv_pct = 0;

   slot_header_allocator u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_slot_index  (req_slot_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_slot_used   (rsp_slot_used),
      .rsp_found_index (rsp_found_index),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // header store model: one read-modify-write or one scan per word
   function automatic rsp_word_type predict_header_op(func_type f, logic [IDX_W-1:0] idx);
      rsp_word_type     r;
      int               n;
      int               g;
      int               j;
      bit               hit;
      logic [HDR_W-1:0] h;
      r   = '{STS_OK, 1'b0, '0};
      n   = (slot_limit_model > NSLOT) ? NSLOT : int'(slot_limit_model);
      hit = 1'b0;
      if (f == FUNC_FIND) begin
         for (g = 0; g < n && !hit; g += JL) begin
            // groups whose head count is zero are skipped outright
            if (hdr_model[g][7:1] != 0) begin
               for (j = 0; j < JL && g + j < n && !hit; j++) begin
                  if (!hdr_model[g + j][0]) begin
                     r.found = IDX_W'(g + j);
                     hit     = 1'b1;
                  end
               end
            end
         end
         if (!hit)
            r = '{STS_NO_FREE, 1'b0, '0};
      end else if (int'(idx) >= n) begin
         r.st = STS_RANGE;
      end else begin
         h = hdr_model[idx];
         case (f)
            FUNC_FREE: begin
               if (!h[0]) r.st = STS_FREE;
               else       h[0] = 1'b0;
            end
            FUNC_MARK: begin
               if (h[0]) r.st = STS_USED;
               else      h[0] = 1'b1;
            end
            FUNC_CNT_UP: begin
               if (h[7:1] < JL) h = h + 8'd2;
            end
            FUNC_CNT_DN: begin
               if (h[7:1] != 0) h = h - 8'd2;
            end
            FUNC_RST_GRP: begin
               h = HDR_W'(JL << 1) & 8'hFE;
            end
            FUNC_TEST: begin
               r.used = h[0];
            end
            default: begin
            end
         endcase
         hdr_model[idx] = h;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rcv_pct);
   end

   // request acceptance feeds the model; response acceptance is checked
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en)
            slot_limit_model = csr_wr_data;
         if (req_valid && !req_stall) begin
            next_rsp = predict_header_op(req_func, req_slot_index);
            if (req_chk)
               next_rsp = req_ref;
            pending_rsp = {pending_rsp, next_rsp};
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: expected no response, actual status=%0d used=%0d found=%0d",
                        $time, rsp_status, rsp_slot_used, rsp_found_index);
               mismatch_seen = 1'b1;
            end else begin
               got_rsp = pending_rsp.pop_front();
               if (rsp_status !== got_rsp.st) begin
                  $display("%0t: status expected %0d actual %0d", $time, got_rsp.st,
                           rsp_status);
                  mismatch_seen = 1'b1;
               end
               if (rsp_slot_used !== got_rsp.used) begin
                  $display("%0t: slot_used expected %0d actual %0d", $time, got_rsp.used,
                           rsp_slot_used);
                  mismatch_seen = 1'b1;
               end
               if (rsp_found_index !== got_rsp.found) begin
                  $display("%0t: found_index expected %0d actual %0d", $time,
                           got_rsp.found, rsp_found_index);
                  mismatch_seen = 1'b1;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("slot_header_allocator: mismatch");
         $finish;
      end
   end

   // present one word and hold it until taken
   task automatic put_word(input func_type f, input logic [IDX_W-1:0] idx,
                           input logic chk, input rsp_word_type ex);
      while ($urandom_range(99) < snd_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= f;
      req_slot_index <= idx;
      req_chk        <= chk;
      req_ref        <= ex;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   task automatic send(input func_type f, input int idx);
      put_word(f, IDX_W'(idx), 1'b0, '0);
   endtask

   // sender holds off until every pending response has come back
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_slot_count(input logic [CSR_W-1:0] v);
      drain();
      csr_wr_data <= v;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(input int cnt_cfg, input int mode);
      int       n;
      int       base;
      int       k;
      int       kind;
      int       j;
      int       start;
      bit       paused;
      func_type f;
      write_slot_count(CSR_W'(cnt_cfg));
      snd_pct = (mode == 1) ? 85 : (mode == 3) ? 13 : 0;
      rcv_pct = (mode == 2) ? 85 : (mode == 3) ? 13 : 0;
      n       = (cnt_cfg > NSLOT) ? NSLOT : cnt_cfg;
      start   = words_sent;
      paused  = 1'b0;
      while (words_sent - start < PHASE_WORDS) begin
         if (!paused && words_sent - start >= PHASE_WORDS / 2) begin
            drain();
            paused = 1'b1;
         end
         kind = $urandom_range(99);
         if (kind < 40) begin
            // set up a group, fill part of it, then search
            base = $urandom_range((n - 1) / JL) * JL;
            send(FUNC_RST_GRP, base);
            for (j = 0; j < JL && base + j < n; j++)
               if ($urandom_range(99) < 70)
                  send(FUNC_MARK, base + j);
            if ($urandom_range(3) == 0)
               send(FUNC_FREE, base + $urandom_range(JL - 1));
            send(FUNC_FIND, $urandom_range(1023));
         end else if (kind < 55) begin
            // push a head count towards saturation or zero
            base = $urandom_range((n - 1) / JL) * JL;
            k    = $urandom_range(10, 1);
            f    = $urandom_range(1) ? FUNC_CNT_UP : FUNC_CNT_DN;
            repeat (k) send(f, base);
            send(FUNC_FIND, $urandom_range(1023));
         end else if (kind < 85) begin
            send(func_type'($urandom_range(7)), $urandom_range(n - 1));
         end else if (kind < 93 && n < NSLOT) begin
            send(func_type'($urandom_range(7)), $urandom_range(1023, n));
         end else begin
            send(func_type'($urandom_range(7)), $urandom_range(1023));
         end
      end
   endtask

   initial begin
      for (int i = 0; i < NSLOT; i++)
         hdr_model[i] = '0;
      slot_limit_model = SLOT_COUNT_RST;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (DIR_TAB[i]) begin
         if (DIR_TAB[i].is_cfg)
            write_slot_count(DIR_TAB[i].cfg);
         else
            put_word(DIR_TAB[i].f, DIR_TAB[i].idx, DIR_TAB[i].chk, DIR_TAB[i].ex);
      end

      // mostly small pages so that searches stay short
      run_phase(24, 0);
      run_phase(1024, 1);
      run_phase(1, 2);
      run_phase(17, 3);
      run_phase(64, 0);
      run_phase(8, 1);
      run_phase(1023, 2);
      run_phase(40, 3);

      snd_pct = 0;
      rcv_pct = 0;
      drain();
      repeat (50) @(posedge clock);
      if (!mismatch_seen)
         $display("slot_header_allocator: match");
      else
         $display("slot_header_allocator: mismatch");
      $finish;
   end

endmodule

### files.f
+incdir+hdl
hdl/sha_pkg.sv
hdl/sha_ctrl.sv
hdl/sha_dp.sv
hdl/slot_header_allocator.sv
tb/sv/slot_header_allocator_test.sv
